>>> hdl/lrob_pkg.sv
// Shared types and codes of the byte log ring.
`timescale 1ns / 1ps
`default_nettype none

package lrob_pkg;

    // Item kind carried in the slave tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Field widths fixed by the stream format.
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 32;
    localparam int COUNT_W = 7;

    // One result item as it travels toward the master side.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               is_last;
        logic [INDEX_W-1:0] next_index;
        logic [COUNT_W-1:0] returned_count;
    } t_res;

    // Occupancy status of the output queue.
    typedef struct packed {
        logic [1:0] cnt;
        logic       pop;
    } t_qstat;

endpackage

`default_nettype wire

>>> hdl/log_ring_overwrite_buffer.sv
// Top level of the overwrite-oldest byte log ring.
// Write transfer: back-to-back writes run at one byte per cycle while no read is in progress.
// Read transfer: a span check state, then a size state (span size, count and next index),
// then one ring read per cycle while the output queue has room; each result passes
// through the in-flight register into the output queue. A read holds the input until
// its last result (or the marker of an empty read) is issued, longer while the master side stalls.
// Reset clears both counters; the ring memory is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module log_ring_overwrite_buffer
    import lrob_pkg::*;
#(
    parameter int RING_DEPTH = 16384,
    parameter int MAX_READ   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // data_byte[7:0], start_index[39:8], resume_from_index[40], clear_after[41],
    // max_count[48:42], zero fill [55:49]
    input  wire logic [55:0] s_axis_tdata,
    // kind[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0], next_index[39:8], returned_count[46:40], zero fill [47]
    output logic [47:0]      m_axis_tdata,
    // byte_valid[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int AW = $clog2(RING_DEPTH);

    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;
    t_qstat            w_qstat;
    logic              w_push;
    t_res              w_res;
    t_res              w_head;

    // Ring storage.
    lrob_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Counters and read sequencer.
    lrob_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_start_index (s_axis_tdata[39:8]),
        .i_resume      (s_axis_tdata[40]),
        .i_clear       (s_axis_tdata[41]),
        .i_max_count   (s_axis_tdata[48:42]),
        .o_ram_we      (w_ram_we),
        .o_ram_waddr   (w_ram_waddr),
        .o_ram_wdata   (w_ram_wdata),
        .o_ram_re      (w_ram_re),
        .o_ram_raddr   (w_ram_raddr),
        .i_ram_rdata   (w_ram_rdata),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_res         (w_res)
    );

    // Output queue decouples the master side from the ring read.
    lrob_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_stat  (w_qstat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_head)
    );

    // Master stream packing.
    assign m_axis_tdata = {1'b0, w_head.returned_count, w_head.next_index, w_head.out_byte};
    assign m_axis_tuser = w_head.byte_valid;
    assign m_axis_tlast = w_head.is_last;

endmodule

`default_nettype wire

>>> hdl/lrob_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lrob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lrob_outq.sv
// Two-entry result queue that drives the master stream.
`timescale 1ns / 1ps
`default_nettype none

module lrob_outq
    import lrob_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_res   i_res,
    output t_qstat      o_stat,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_res        o_res
);

    t_res       r_ent [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop      = o_valid && i_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_ent[r_rd];
    assign o_stat.cnt = r_cnt;
    assign o_stat.pop = w_pop;

    // Entry payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_res;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

>>> hdl/lrob_ctrl.sv
// Counter state, read sequencer and ring memory port control.
`timescale 1ns / 1ps
`default_nettype none

module lrob_ctrl
    import lrob_pkg::*;
#(
    parameter int RING_DEPTH = 16384,
    parameter int MAX_READ   = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_kind,
    input  wire logic [BYTE_W-1:0]             i_data_byte,
    input  wire logic [INDEX_W-1:0]            i_start_index,
    input  wire logic                          i_resume,
    input  wire logic                          i_clear,
    input  wire logic [COUNT_W-1:0]            i_max_count,
    output logic                               o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]      o_ram_waddr,
    output logic [BYTE_W-1:0]                  o_ram_wdata,
    output logic                               o_ram_re,
    output logic [$clog2(RING_DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [BYTE_W-1:0]             i_ram_rdata,
    input  wire t_qstat                        i_qstat,
    output logic                               o_push,
    output t_res                               o_res
);

    localparam int               AW      = $clog2(RING_DEPTH);
    localparam logic [INDEX_W-1:0] DEPTH_W = INDEX_W'(RING_DEPTH);
    localparam logic [COUNT_W-1:0] MAX_W   = COUNT_W'(MAX_READ);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_SIZE  = 4'b0100,
        ST_RUN   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [INDEX_W-1:0] r_prod, n_prod;
    logic [INDEX_W-1:0] r_cons, n_cons;
    logic [INDEX_W-1:0] r_cur, n_cur;
    logic [INDEX_W-1:0] r_sidx, n_sidx;
    logic [INDEX_W-1:0] r_avail, n_avail;
    logic [INDEX_W-1:0] r_next, n_next;
    logic               r_resume, n_resume;
    logic               r_clr, n_clr;
    logic [COUNT_W-1:0] r_lim, n_lim;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_inf_vld, n_inf_vld;
    t_res               r_inf, n_inf;

    logic               w_wr_acc;
    logic               w_rd_acc;
    logic [INDEX_W-1:0] w_prod_inc;
    logic               w_in_span;
    logic [2:0]         w_occ;
    logic               w_room;
    logic [INDEX_W-1:0] w_behind;
    logic [COUNT_W-1:0] w_take_sz;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_wr_acc   = i_in_valid && o_in_ready && (i_kind == KIND_WRITE);
    assign w_rd_acc   = i_in_valid && o_in_ready && (i_kind == KIND_READ);
    assign w_prod_inc = r_prod + 32'd1;
    assign w_behind   = r_prod - r_next;

    // Resume index must lie in (consumer, producer] with 32-bit wrap.
    always_comb begin
        if (r_cons <= r_prod) begin
            w_in_span = (r_cons < r_sidx) && (r_sidx <= r_prod);
        end else begin
            w_in_span = (r_cons < r_sidx) || (r_sidx <= r_prod);
        end
    end

    // Room in the output queue counts the read already in flight.
    assign w_occ  = {1'b0, i_qstat.cnt} + {2'b00, r_inf_vld} - {2'b00, i_qstat.pop};
    assign w_room = (w_occ < 3'd2);

    // Ring write port: one byte per write transfer.
    assign o_ram_we    = w_wr_acc;
    assign o_ram_waddr = r_prod[AW-1:0];
    assign o_ram_wdata = i_data_byte;

    // The in-flight result is pushed into the queue in the cycle after its read.
    assign o_push = r_inf_vld;
    always_comb begin
        o_res          = r_inf;
        o_res.out_byte = r_inf.byte_valid ? i_ram_rdata : '0;
    end

    // Next-state logic.
    always_comb begin
        n_state   = r_state;
        n_prod    = r_prod;
        n_cons    = r_cons;
        n_cur     = r_cur;
        n_sidx    = r_sidx;
        n_avail   = r_avail;
        n_next    = r_next;
        n_resume  = r_resume;
        n_clr     = r_clr;
        n_lim     = r_lim;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_inf_vld = 1'b0;
        n_inf     = r_inf;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_cur[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_wr_acc) begin
                    n_prod = w_prod_inc;
                    if ((w_prod_inc - r_cons) > DEPTH_W) begin
                        n_cons = w_prod_inc - DEPTH_W;
                    end
                end
                if (w_rd_acc) begin
                    n_sidx   = i_start_index;
                    n_resume = i_resume;
                    n_clr    = i_clear;
                    n_lim    = (i_max_count > MAX_W) ? MAX_W : i_max_count;
                    n_state  = ST_START;
                end
            end
            ST_START: begin
                n_cur   = (r_resume && w_in_span) ? r_sidx : r_cons;
                n_state = ST_SIZE;
            end
            ST_SIZE: begin
                n_avail = r_prod - r_cur;
                n_state = ST_RUN;
                // Byte count and next index are registered from this span.
            end
            ST_RUN: begin
                // Clear happens once, on the first cycle of the run.
                if (r_clr) begin
                    n_clr  = 1'b0;
                    n_cons = (w_behind > DEPTH_W) ? (r_prod - DEPTH_W) : r_next;
                end
                if (w_room) begin
                    n_inf_vld            = 1'b1;
                    n_inf.next_index     = r_next;
                    n_inf.returned_count = r_cnt;
                    n_inf.out_byte       = '0;
                    if (r_left == '0) begin
                        // Empty read gives one marker result.
                        n_inf.byte_valid = 1'b0;
                        n_inf.is_last    = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        o_ram_re         = 1'b1;
                        n_inf.byte_valid = 1'b1;
                        n_inf.is_last    = (r_left == COUNT_W'(1));
                        n_cur            = r_cur + 32'd1;
                        n_left           = r_left - COUNT_W'(1);
                        if (r_left == COUNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Byte count of the read, taken from the span sized in the size state.
    assign w_take_sz = (n_avail < {{(INDEX_W-COUNT_W){1'b0}}, r_lim}) ?
                       n_avail[COUNT_W-1:0] : r_lim;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_prod    <= '0;
            r_cons    <= '0;
            r_clr     <= 1'b0;
            r_inf_vld <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_prod    <= n_prod;
            r_cons    <= n_cons;
            r_clr     <= n_clr;
            r_inf_vld <= n_inf_vld;
            r_left    <= (r_state == ST_SIZE) ? w_take_sz : n_left;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_sidx   <= n_sidx;
        r_avail  <= n_avail;
        r_resume <= n_resume;
        r_lim    <= n_lim;
        r_inf    <= n_inf;
        if (r_state == ST_SIZE) begin
            r_cnt  <= w_take_sz;
            r_next <= r_cur + {{(INDEX_W-COUNT_W){1'b0}}, w_take_sz};
        end else begin
            r_cnt  <= n_cnt;
            r_next <= n_next;
        end
    end

    // Unread span never grows past the ring.
    a_span_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod - r_cons) <= DEPTH_W)
        else $error("unread span exceeds ring depth");

    // No result is pushed into a full queue.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !((i_qstat.cnt == 2'd2) && !i_qstat.pop))
        else $error("result pushed into full queue");

    // A write transfer advances the producer by one.
    a_prod_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_acc |=> (r_prod == $past(w_prod_inc)))
        else $error("producer did not advance on write");

    // Remaining byte count stays within the read cap.
    a_left_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left <= MAX_W))
        else $error("read length above cap");

endmodule

`default_nettype wire
